### rtl/mpfs_pkg.sv
// shared types and constants for the page-mode frame store streamer
// no dependencies; used by mpfs_ctrl, mpfs_dp, the top level and the testbench
`default_nettype none

package mpfs_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_DRAW    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_TICK_OUT
  } state_e;

  // panel command bytes sent ahead of each page
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // controller to datapath commands
  typedef struct packed {
    logic draw_rd;    // read the byte a draw word targets, latch its address
    logic draw_wr;    // write back the modified byte
    logic tick_rd;    // read the byte for the current refresh position
    logic tick_emit;  // load the output register and advance the refresh counters
    logic clr_start;  // restart the clear sweep at address zero
    logic clr_wr;     // write zero at the sweep address
    logic arm;        // arm a refresh from page zero
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic on_screen;  // incoming draw coordinates fall inside the panel
    logic armed;      // a refresh is in progress
    logic clr_done;   // sweep address is at the last entry
    logic can_emit;   // output register is free or drains this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/mpfs_if.sv
// valid/ready channel interfaces for the input and result words
// no dependencies
`default_nettype none

interface mpfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  logic       pixel_on;

  modport source (output valid, output opcode, output x_coord, output y_coord,
                  output pixel_on, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord,
                  input pixel_on, output ready);
endinterface

interface mpfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_last;

  modport source (output valid, output out_byte, output is_data, output frame_last,
                  input ready);
  modport sink   (input valid, input out_byte, input is_data, input frame_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/mpfs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mpfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/mpfs_ctrl.sv
// controller state machine: sequences draws, ticks and clear sweeps
// depends on mpfs_pkg
`default_nettype none

module mpfs_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [1:0]           opcode_i,
  input  wire mpfs_pkg::dp_stat_t   stat_i,
  output      logic                 ready_o,
  output      mpfs_pkg::ctrl_cmd_t  cmd_o
);

  mpfs_pkg::state_e state_q, state_d;
  mpfs_pkg::op_e    op;

  assign op = mpfs_pkg::op_e'(opcode_i);

  // state register, reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpfs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ready_o = 1'b0;
    unique case (state_q)
      mpfs_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = mpfs_pkg::ST_IDLE;
        end
      end
      mpfs_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          unique case (op)
            mpfs_pkg::OP_DRAW: begin
              if (stat_i.on_screen) begin
                cmd_o.draw_rd = 1'b1;
                state_d       = mpfs_pkg::ST_DRAW_WR;
              end
            end
            mpfs_pkg::OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              cmd_o.arm       = 1'b1;
              state_d         = mpfs_pkg::ST_CLEAR;
            end
            mpfs_pkg::OP_REFRESH: begin
              cmd_o.arm = 1'b1;
            end
            mpfs_pkg::OP_TICK: begin
              if (stat_i.armed) begin
                cmd_o.tick_rd = 1'b1;
                state_d       = mpfs_pkg::ST_TICK_OUT;
              end
            end
            default: begin
              state_d = mpfs_pkg::ST_IDLE;
            end
          endcase
        end
      end
      mpfs_pkg::ST_DRAW_WR: begin
        cmd_o.draw_wr = 1'b1;
        state_d       = mpfs_pkg::ST_IDLE;
      end
      mpfs_pkg::ST_TICK_OUT: begin
        if (stat_i.can_emit) begin
          cmd_o.tick_emit = 1'b1;
          state_d         = mpfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpfs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mpfs_dp.sv
// datapath: frame store, draw read-modify-write, refresh counters, output register
// depends on mpfs_pkg and mpfs_ram
`default_nettype none

module mpfs_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           x_coord_i,
  input  wire logic [7:0]           y_coord_i,
  input  wire logic                 pixel_on_i,
  input  wire mpfs_pkg::ctrl_cmd_t  cmd_i,
  input  wire logic                 out_ready_i,
  output      mpfs_pkg::dp_stat_t   stat_o,
  output      logic                 out_valid_o,
  output      logic [7:0]           out_byte_o,
  output      logic                 is_data_o,
  output      logic                 frame_last_o
);

  localparam int PB    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CB    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW    = CB + PB;
  localparam int DEPTH = 2 ** AW;
  localparam int BW    = $clog2(COLUMNS + 3);

  localparam logic [8:0]    COL_LIMIT = 9'(COLUMNS);
  localparam logic [8:0]    ROW_LIMIT = 9'(PAGES * 8);
  localparam logic [PB-1:0] PAGE_LAST = PB'(PAGES - 1);
  localparam logic [BW-1:0] POS_LAST  = BW'(COLUMNS + 2);
  localparam logic [BW-1:0] POS_DATA  = BW'(3);

  logic [AW-1:0] draw_addr, tick_addr, addr_q, clr_q, waddr, raddr;
  logic [PB-1:0] draw_pg, page_q;
  logic [BW-1:0] byte_q, col_w;
  logic [7:0]    mask_q, rdata, wdata, byte_val;
  logic          on_q, armed_q, we, re, last_pos;
  logic          out_valid_q, is_data_q, frame_last_q;
  logic [7:0]    out_byte_q;

  // draw and refresh positions to store addresses
  assign draw_pg   = PAGE_LAST - y_coord_i[PB+2:3];
  assign draw_addr = {x_coord_i[CB-1:0], draw_pg};
  assign col_w     = byte_q - POS_DATA;
  assign tick_addr = {col_w[CB-1:0], page_q};

  // store port muxing
  assign re    = cmd_i.draw_rd | cmd_i.tick_rd;
  assign raddr = cmd_i.draw_rd ? draw_addr : tick_addr;
  assign we    = cmd_i.draw_wr | cmd_i.clr_wr;
  assign waddr = cmd_i.clr_wr ? clr_q : addr_q;
  assign wdata = cmd_i.clr_wr ? 8'h00 : (on_q ? (rdata | mask_q) : (rdata & ~mask_q));

  mpfs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // draw word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_rd) begin
      addr_q <= draw_addr;
      mask_q <= 8'h80 >> y_coord_i[2:0];
      on_q   <= pixel_on_i;
    end
  end

  // clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // refresh position counters
  assign last_pos = (byte_q == POS_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      page_q  <= '0;
      byte_q  <= '0;
    end else if (cmd_i.arm) begin
      armed_q <= 1'b1;
      page_q  <= '0;
      byte_q  <= '0;
    end else if (cmd_i.tick_emit) begin
      if (last_pos) begin
        byte_q <= '0;
        if (page_q == PAGE_LAST) begin
          armed_q <= 1'b0;
          page_q  <= '0;
        end else begin
          page_q <= page_q + PB'(1);
        end
      end else begin
        byte_q <= byte_q + BW'(1);
      end
    end
  end

  // command or data byte for the current position
  always_comb begin
    case (byte_q)
      BW'(0):  byte_val = mpfs_pkg::CMD_PAGE_BASE + 8'(page_q);
      BW'(1):  byte_val = mpfs_pkg::CMD_COL_LOW;
      BW'(2):  byte_val = mpfs_pkg::CMD_COL_HIGH;
      default: byte_val = rdata;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_emit) begin
      out_byte_q   <= byte_val;
      is_data_q    <= (byte_q >= POS_DATA);
      frame_last_q <= last_pos && (page_q == PAGE_LAST);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_data_o    = is_data_q;
  assign frame_last_o = frame_last_q;

  // status back to the controller
  assign stat_o.on_screen = ({1'b0, x_coord_i} < COL_LIMIT) && ({1'b0, y_coord_i} < ROW_LIMIT);
  assign stat_o.armed     = armed_q;
  assign stat_o.clr_done  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.can_emit  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

### rtl/mono_page_framebuffer_streamer_unit.sv
// top level of the page-mode frame store streamer
// depends on mpfs_pkg, mpfs_if, mpfs_ram, mpfs_ctrl and mpfs_dp
`default_nettype none

// Monochrome COLUMNS x (PAGES*8) frame store of column bytes with a panel refresh
// streamer. Words are taken one at a time. A draw reads the store, then writes
// the modified byte back; an off-screen draw, a refresh, or a tick while no
// refresh is armed is taken without leaving idle. A tick reads the store, then
// loads the output register once it is free or drains. A clear restarts the
// sweep, arms a refresh from page zero and writes zero to every entry; the store holds
// 2**(max(1, ceil(log2(COLUMNS))) + max(1, ceil(log2(PAGES)))) entries
// (1024 by default), all set by the single write port of the store. The same
// clearing pass runs after reset; no word is taken until it ends. One finished
// result word can wait in the output register while the next word is taken.
module mono_page_framebuffer_streamer_unit #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mpfs_in_if.sink          in_i,
  mpfs_out_if.source       out_o
);

  mpfs_pkg::ctrl_cmd_t cmd;
  mpfs_pkg::dp_stat_t  stat;

  mpfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .opcode_i (in_i.opcode),
    .stat_i   (stat),
    .ready_o  (in_i.ready),
    .cmd_o    (cmd)
  );

  mpfs_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .x_coord_i    (in_i.x_coord),
    .y_coord_i    (in_i.y_coord),
    .pixel_on_i   (in_i.pixel_on),
    .cmd_i        (cmd),
    .out_ready_i  (out_o.ready),
    .stat_o       (stat),
    .out_valid_o  (out_o.valid),
    .out_byte_o   (out_o.out_byte),
    .is_data_o    (out_o.is_data),
    .frame_last_o (out_o.frame_last)
  );

`ifndef SYNTHESIS
  // a new result word only follows an emit command
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.tick_emit))
    else $error("result word appeared without an emit");

  // no word is taken during a clear sweep
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !in_i.ready)
    else $error("input ready during clear sweep");

  // a draw write back always follows its read
  a_draw_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.draw_wr |-> $past(cmd.draw_rd))
    else $error("draw write without preceding read");

  // an emit never overwrites a result word still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !cmd.tick_emit)
    else $error("result word overwritten");
`endif

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the page-mode frame store streamer
// depends on mpfs_pkg, mpfs_if and the mono_page_framebuffer_streamer_unit top level
// directed table first (some results typed in), then one full frame, then random sequences, checked against a predictor
module tb;
  import mpfs_pkg::*;

  localparam int NCOL  = 128;
  localparam int NPAGE = 8;
  localparam int NROW  = NPAGE * 8;
  localparam int RAND_WORDS = 1500;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int N_DIR = 25;

  // one byte sent to the panel link
  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  // one directed word, with an optional typed-in result
  typedef struct packed {
    op_e         op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        on;
    logic        typed;
    panel_byte_t pb;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mpfs_in_if  in_if ();
  mpfs_out_if out_if ();

  mono_page_framebuffer_streamer_unit #(
    .COLUMNS(NCOL),
    .PAGES  (NPAGE)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // predictor state: shadow of the frame store and the refresh counters
  logic [7:0]  frame_img [NCOL*NPAGE];
  bit          stream_armed;
  int          stream_page;
  int          stream_pos;
  panel_byte_t panel_bytes_q [$];

  int n_words, n_ignored, n_draws, n_clears, n_refreshes;
  int n_results, n_cmd_bytes, n_data_bytes, n_frames, n_mismatch;
  int send_burst, recv_burst;

  stim_row_t dir_rows [N_DIR] = '{
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd0,   8'd0,   1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd127, 8'd63,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd128, 8'd0,   1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd0,   8'd64,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd255, 8'd255, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_PAGE_BASE, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_COL_LOW, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_COL_HIGH, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{OP_DRAW,    8'd1,   8'd63,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd1,   8'd63,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_PAGE_BASE, 1'b0, 1'b0}},
    '{OP_CLEAR,   8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_PAGE_BASE, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_COL_LOW, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd0,   8'd56,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b1, '{CMD_COL_HIGH, 1'b0, 1'b0}},
    '{OP_TICK,    8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd200, 8'd10,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd127, 8'd0,   1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{OP_CLEAR,   8'd0,   8'd0,   1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}}
  };

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycles to idle before the next word, with occasional gap-free stretches
  function automatic int pick_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // start a refresh from page zero, position zero
  task automatic arm_stream();
    stream_armed = 1'b1;
    stream_page  = 0;
    stream_pos   = 0;
  endtask

  // update the shadow state for one accepted word and work out its panel byte
  task automatic predict_word(input op_e op, input logic [7:0] x, input logic [7:0] y,
                              input logic on, output bit emits, output panel_byte_t pb);
    int         pg;
    int         addr;
    logic [7:0] mask;
    emits = 1'b0;
    pb    = '0;
    case (op)
      OP_DRAW: begin
        if (int'(x) < NCOL && int'(y) < NROW) begin
          pg   = NPAGE - 1 - int'(y >> 3);
          mask = 8'h80 >> y[2:0];
          addr = int'(x) * NPAGE + pg;
          if (on) frame_img[addr] = frame_img[addr] | mask;
          else    frame_img[addr] = frame_img[addr] & ~mask;
          n_draws++;
        end else begin
          n_ignored++;
        end
      end
      OP_CLEAR: begin
        foreach (frame_img[i]) frame_img[i] = 8'h00;
        arm_stream();
        n_clears++;
      end
      OP_REFRESH: begin
        arm_stream();
        n_refreshes++;
      end
      default: begin
        if (!stream_armed) begin
          n_ignored++;
        end else begin
          emits = 1'b1;
          if (stream_pos == 0)      pb.value = 8'(int'(CMD_PAGE_BASE) + stream_page);
          else if (stream_pos == 1) pb.value = CMD_COL_LOW;
          else if (stream_pos == 2) pb.value = CMD_COL_HIGH;
          else begin
            pb.value   = frame_img[(stream_pos - 3) * NPAGE + stream_page];
            pb.is_data = 1'b1;
          end
          // advance position, page, and close the frame after the last page
          if (stream_pos >= NCOL + 2) begin
            stream_pos = 0;
            if (stream_page + 1 >= NPAGE) begin
              pb.last      = 1'b1;
              stream_armed = 1'b0;
              stream_page  = 0;
            end else begin
              stream_page++;
            end
          end else begin
            stream_pos++;
          end
        end
      end
    endcase
  endtask

  // offer one word, wait for its handshake, then record what it should cause
  task automatic send_word(input op_e op, input logic [7:0] x, input logic [7:0] y,
                           input logic on, input logic typed, input panel_byte_t typed_pb);
    int          gap;
    bit          emits;
    panel_byte_t pb;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.x_coord  <= x;
    in_if.y_coord  <= y;
    in_if.pixel_on <= on;
    do @(posedge clk); while (!in_if.ready);
    n_words++;
    predict_word(op, x, y, on, emits, pb);
    if (emits) panel_bytes_q.push_back(typed ? typed_pb : pb);
  endtask

  // random on-screen draw word
  task automatic send_rand_draw();
    send_word(OP_DRAW, 8'($urandom_range(0, NCOL - 1)), 8'($urandom_range(0, NROW - 1)),
              1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // random word with every field unconstrained
  task automatic send_noise();
    send_word(op_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom),
              1'b0, '0);
  endtask

  // hold the sender until every expected byte has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (panel_bytes_q.size() != 0);
  endtask

  // main stimulus
  initial begin
    int kind;
    int len;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.opcode   = OP_DRAW;
    in_if.x_coord  = 8'h00;
    in_if.y_coord  = 8'h00;
    in_if.pixel_on = 1'b0;
    out_if.ready   = 1'b0;
    foreach (frame_img[i]) frame_img[i] = 8'h00;
    stream_armed = 1'b0;
    stream_page  = 0;
    stream_pos   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].on,
                dir_rows[i].typed, dir_rows[i].pb);
    drain_results();

    // one complete frame with draws mixed in, so the final byte is reached
    send_word(OP_REFRESH, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    while (stream_armed) begin
      if ($urandom_range(0, 9) == 0) send_rand_draw();
      else send_word(OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    end
    drain_results();

    // random sequences, mostly well-formed refresh runs
    while (n_words - n_ignored < N_DIR + RAND_WORDS) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        if ($urandom_range(0, 3) == 0) send_word(OP_CLEAR, 8'($urandom), 8'($urandom),
                                                 1'($urandom), 1'b0, '0);
        else send_word(OP_REFRESH, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
        len = $urandom_range(5, 150);
        repeat (len) begin
          kind = $urandom_range(0, 99);
          if (kind < 85)      send_word(OP_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                                        1'b0, '0);
          else if (kind < 98) send_rand_draw();
          else                send_noise();
        end
      end else if (kind < 15) begin
        repeat ($urandom_range(5, 30)) send_rand_draw();
      end else if (kind < 18) begin
        repeat ($urandom_range(5, 30)) send_noise();
      end else begin
        repeat ($urandom_range(1, 10)) send_word(OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      end
    end

    // wait for the tail, then report
    drain_results();
    repeat (16) @(posedge clk);
    $display("covered %0d words: %0d draws, %0d ignored, %0d clears, %0d refreshes",
             n_words, n_draws, n_ignored, n_clears, n_refreshes);
    $display("checked %0d bytes: %0d command, %0d data, %0d complete frames, %0d mismatches",
             n_results, n_cmd_bytes, n_data_bytes, n_frames, n_mismatch);
    if (n_mismatch == 0 && panel_bytes_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random ready gaps and one long hold-off
  initial begin
    int gap;
    int n_taken;
    bit held;
    n_taken = 0;
    held    = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_gap(recv_burst);
      if (!held && n_taken >= HOLD_AT_RESULT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      n_taken++;
    end
  end

  // compare each delivered byte with the oldest expected one
  always @(posedge clk) begin : chk
    panel_byte_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (out_if.is_data) n_data_bytes++;
      else n_cmd_bytes++;
      if (out_if.frame_last) n_frames++;
      if (panel_bytes_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("mismatch: unexpected byte %h is_data %b frame_last %b",
                   out_if.out_byte, out_if.is_data, out_if.frame_last);
      end else begin
        want = panel_bytes_q.pop_front();
        if (want.value !== out_if.out_byte || want.is_data !== out_if.is_data ||
            want.last !== out_if.frame_last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at byte %0d: exp %h/%b/%b got %h/%b/%b (byte/data/last)",
                     n_results, want.value, want.is_data, want.last,
                     out_if.out_byte, out_if.is_data, out_if.frame_last);
        end
      end
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
rtl/mpfs_pkg.sv
rtl/mpfs_if.sv
rtl/mpfs_ram.sv
rtl/mpfs_ctrl.sv
rtl/mpfs_dp.sv
rtl/mono_page_framebuffer_streamer_unit.sv
dv/tb.sv
